/* src/jddm_pkg.sv */
// ----------------------------------------------------------------------------
// Joystick drive mixer package
// Shared types, register map and constants of the joystick drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int ADC_BITS_DEF = 12;
	localparam int NORM_W       = 17;
	localparam int PWM_W        = 14;
	localparam int CFG_ADDR_W   = 5;
	localparam int APB_DATA_W   = 32;

	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [12:0] PWM_FULL = 13'd8190;

	typedef enum logic [2:0] {
		REG_X_REST     = 3'd0,
		REG_Y_REST     = 3'd1,
		REG_RANGE_X    = 3'd2,
		REG_RANGE_Y    = 3'd3,
		REG_X_DEAD     = 3'd4,
		REG_Y_DEAD     = 3'd5,
		REG_STEER_GAIN = 3'd6,
		REG_DIFF_LIMIT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] x_rest;
		logic [11:0] y_rest;
		logic [11:0] range_x;
		logic [11:0] range_y;
		logic [15:0] x_dead;
		logic [15:0] y_dead;
		logic [15:0] steer_gain;
		logic [15:0] diff_limit;
	} cfg_t;

	localparam logic [11:0] RST_REST       = 12'd2048;
	localparam logic [11:0] RST_RANGE      = 12'd2048;
	localparam logic [15:0] RST_DB_X       = 16'd3277;
	localparam logic [15:0] RST_DB_Y       = 16'd2621;
	localparam logic [15:0] RST_GAIN       = 16'd26214;
	localparam logic [15:0] RST_DIFF_LIMIT = 16'd44237;

endpackage

/* src/jddm_if.sv */
// ----------------------------------------------------------------------------
// Joystick drive mixer channels
// Valid/ready channels for sample pairs and drive words.
// ----------------------------------------------------------------------------
interface jddm_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] x_sample;
	logic [11:0] y_sample;

	modport source (output valid, x_sample, y_sample, input ready);
	modport sink (input valid, x_sample, y_sample, output ready);
endinterface

interface jddm_out_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] left_drive;
	logic signed [13:0] right_drive;
	logic signed [16:0] steer_norm;
	logic signed [16:0] throttle_norm;

	modport source (output valid, left_drive, right_drive, steer_norm, throttle_norm,
		input ready);
	modport sink (input valid, left_drive, right_drive, steer_norm, throttle_norm,
		output ready);
endinterface

/* src/jddm_regs.sv */
// ----------------------------------------------------------------------------
// Joystick drive mixer registers
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module jddm_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [jddm_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [jddm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [jddm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output jddm_pkg::cfg_t                     cfg
);
	import jddm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_rest     <= RST_REST;
			cfg_q.y_rest     <= RST_REST;
			cfg_q.range_x    <= RST_RANGE;
			cfg_q.range_y    <= RST_RANGE;
			cfg_q.x_dead     <= RST_DB_X;
			cfg_q.y_dead     <= RST_DB_Y;
			cfg_q.steer_gain <= RST_GAIN;
			cfg_q.diff_limit <= RST_DIFF_LIMIT;
		end else if (wr) begin
			unique case (idx)
				REG_X_REST:     cfg_q.x_rest     <= pwdata[11:0];
				REG_Y_REST:     cfg_q.y_rest     <= pwdata[11:0];
				REG_RANGE_X:    cfg_q.range_x    <= pwdata[11:0];
				REG_RANGE_Y:    cfg_q.range_y    <= pwdata[11:0];
				REG_X_DEAD:     cfg_q.x_dead     <= pwdata[15:0];
				REG_Y_DEAD:     cfg_q.y_dead     <= pwdata[15:0];
				REG_STEER_GAIN: cfg_q.steer_gain <= pwdata[15:0];
				REG_DIFF_LIMIT: cfg_q.diff_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_X_REST:     prdata = {20'd0, cfg_q.x_rest};
			REG_Y_REST:     prdata = {20'd0, cfg_q.y_rest};
			REG_RANGE_X:    prdata = {20'd0, cfg_q.range_x};
			REG_RANGE_Y:    prdata = {20'd0, cfg_q.range_y};
			REG_X_DEAD:     prdata = {16'd0, cfg_q.x_dead};
			REG_Y_DEAD:     prdata = {16'd0, cfg_q.y_dead};
			REG_STEER_GAIN: prdata = {16'd0, cfg_q.steer_gain};
			REG_DIFF_LIMIT: prdata = {16'd0, cfg_q.diff_limit};
			default:        prdata = '0;
		endcase
	end
endmodule

/* src/jddm_div.sv */
// ----------------------------------------------------------------------------
// Joystick drive mixer divider
// Pipelined restoring divider, ceil(Q_W/STAGES) quotient bits per stage.
// ----------------------------------------------------------------------------
module jddm_div #(
	parameter int DEN_W  = 12,
	parameter int Q_W    = 15,
	parameter int STAGES = 3
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] num_hi,
	input  logic [Q_W-1:0]   num_lo,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);
	localparam int SPS = (Q_W + STAGES - 1) / STAGES;

	logic [DEN_W-1:0] rem_s [STAGES];
	logic [Q_W-1:0]   lo_s  [STAGES];
	logic [DEN_W-1:0] den_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [DEN_W-1:0] r_in;
		logic [Q_W-1:0]   l_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W-1:0] r_out;
		logic [Q_W-1:0]   l_out;

		if (g == 0) begin : g_first
			assign r_in = num_hi;
			assign l_in = num_lo;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign l_in = lo_s[g-1];
			assign d_in = den_s[g-1];
		end

		always_comb begin
			logic [DEN_W:0] t;
			r_out = r_in;
			l_out = l_in;
			for (int j = 0; j < SPS; j++) begin
				if (g * SPS + j < Q_W) begin
					t = {r_out, l_out[Q_W-1]};
					if (t >= {1'b0, d_in}) begin
						r_out = DEN_W'(t - {1'b0, d_in});
						l_out = {l_out[Q_W-2:0], 1'b1};
					end else begin
						r_out = t[DEN_W-1:0];
						l_out = {l_out[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_out;
				lo_s[g]  <= l_out;
				den_s[g] <= d_in;
			end
		end
	end

	assign quo = lo_s[STAGES-1];
endmodule

/* src/jddm_delay.sv */
// ----------------------------------------------------------------------------
// Joystick drive mixer delay line
// Stallable shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module jddm_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];
endmodule

/* src/joystick_differential_drive_mixer.sv */
// ----------------------------------------------------------------------------
// Joystick differential drive mixer
// Normalizes a joystick sample pair and mixes it into left/right drive words.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    x_sample, y_sample
//   drive     out  valid/ready    left_drive, right_drive, steer_norm, throttle_norm
//   apb       in   psel/penable   paddr, pwdata, prdata
//
// A word enters every cycle unless the pipeline holds, and passes every stage to the output register.
// The axis and wheel dividers and the three cube/gain multipliers set the depth.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The whole pipeline holds while the output word waits and drive.ready is low.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer #(
	parameter int ADC_BITS = jddm_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	jddm_in_if.sink                         samples,
	jddm_out_if.source                      drive,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jddm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [jddm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [jddm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import jddm_pkg::*;

	localparam int                  MW    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << MW) - 64'd1);
	localparam int                  DEPTH = 15;

	cfg_t cfg;

	jddm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	logic [DEPTH-1:0] vld_q;
	logic             en;

	assign en            = !vld_q[DEPTH-1] || drive.ready;
	assign samples.ready = en;
	assign drive.valid   = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], samples.valid};
		end
	end

	// Stage 1: center and take magnitudes.
	logic [12:0] dx, dy;
	logic [11:0] xmag_s1, ymag_s1;
	logic        xneg_s1, yneg_s1, xsat_s1, ysat_s1;

	assign dx = {1'b0, samples.x_sample & SMASK} - {1'b0, cfg.x_rest};
	assign dy = {1'b0, samples.y_sample & SMASK} - {1'b0, cfg.y_rest};

	always_ff @(posedge clk) begin
		if (en) begin
			xneg_s1 <= dx[12];
			yneg_s1 <= dy[12];
			xmag_s1 <= dx[12] ? 12'(-dx) : dx[11:0];
			ymag_s1 <= dy[12] ? 12'(-dy) : dy[11:0];
			xsat_s1 <= ((dx[12] ? 12'(-dx) : dx[11:0]) >= cfg.range_x) && (dx != '0);
			ysat_s1 <= ((dy[12] ? 12'(-dy) : dy[11:0]) >= cfg.range_y) && (dy != '0);
		end
	end

	// Stages 2 to 4: divide by the axis range.
	logic [14:0] qx_s4, qy_s4;
	logic [3:0]  flags_s4;
	logic [11:0] den_x, den_y;

	assign den_x = (cfg.range_x == '0) ? 12'd1 : cfg.range_x;
	assign den_y = (cfg.range_y == '0) ? 12'd1 : cfg.range_y;

	jddm_div #(.DEN_W(12), .Q_W(15), .STAGES(3)) u_div_x (
		.clk, .en, .num_hi(xmag_s1), .num_lo(15'd0), .den(den_x), .quo(qx_s4)
	);
	jddm_div #(.DEN_W(12), .Q_W(15), .STAGES(3)) u_div_y (
		.clk, .en, .num_hi(ymag_s1), .num_lo(15'd0), .den(den_y), .quo(qy_s4)
	);
	jddm_delay #(.W(4), .N(3)) u_dly_flags (
		.clk, .en, .d({xneg_s1, xsat_s1, yneg_s1, ysat_s1}), .q(flags_s4)
	);

	// Stage 5: saturate and apply the deadband.
	logic [15:0]        xn, yn, xk, yk, xm_s5;
	logic signed [16:0] xv_s5, yv_s5;

	assign xn = flags_s4[2] ? ONE_Q15 : {1'b0, qx_s4};
	assign yn = flags_s4[0] ? ONE_Q15 : {1'b0, qy_s4};
	assign xk = (xn < cfg.x_dead) ? 16'd0 : xn;
	assign yk = (yn < cfg.y_dead) ? 16'd0 : yn;

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s5 <= xk;
			xv_s5 <= flags_s4[3] ? -$signed({1'b0, xk}) : $signed({1'b0, xk});
			yv_s5 <= flags_s4[1] ? -$signed({1'b0, yk}) : $signed({1'b0, yk});
		end
	end

	// Stages 6 to 8: cube the steering magnitude and apply the gain.
	logic [31:0] xsq_s6;
	logic [15:0] xm_s6;
	logic [46:0] xcu_s7;
	logic [61:0] p_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s6 <= xm_s5 * xm_s5;
			xm_s6  <= xm_s5;
			xcu_s7 <= xsq_s6[30:0] * xm_s6;
			p_s8   <= xcu_s7[45:0] * cfg.steer_gain;
		end
	end

	logic [17:0] xy_d8;

	jddm_delay #(.W(18), .N(3)) u_dly_y (
		.clk, .en, .d({xv_s5[16], yv_s5}), .q(xy_d8)
	);

	// Stage 9: mix into wheels and check the difference limit.
	logic signed [18:0] sv, lw, rw;
	logic [15:0]        smag;
	logic [16:0]        labs_s9, rabs_s9, diff_s9;
	logic               lneg_s9, rneg_s9, lim_s9;

	assign smag = p_s8[60:45];
	assign sv   = xy_d8[17] ? -$signed({3'b000, smag}) : $signed({3'b000, smag});
	assign lw   = 19'(signed'(xy_d8[16:0])) + sv;
	assign rw   = 19'(signed'(xy_d8[16:0])) - sv;

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s9 <= lw[18];
			rneg_s9 <= rw[18];
			labs_s9 <= lw[18] ? 17'(-lw) : lw[16:0];
			rabs_s9 <= rw[18] ? 17'(-rw) : rw[16:0];
			diff_s9 <= {smag, 1'b0};
			lim_s9  <= {smag, 1'b0} > {1'b0, cfg.diff_limit};
		end
	end

	// Stage 10: scale by the limit ahead of the division.
	logic [32:0] pl_s10, pr_s10;
	logic [16:0] diff_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s10   <= labs_s9 * cfg.diff_limit;
			pr_s10   <= rabs_s9 * cfg.diff_limit;
			diff_s10 <= diff_s9;
		end
	end

	// Stages 11 to 13: divide by the wheel difference.
	logic [16:0] ql_s13, qr_s13;
	logic [36:0] side_s13;

	jddm_div #(.DEN_W(17), .Q_W(17), .STAGES(3)) u_div_l (
		.clk, .en, .num_hi({1'b0, pl_s10[32:17]}), .num_lo(pl_s10[16:0]),
		.den(diff_s10), .quo(ql_s13)
	);
	jddm_div #(.DEN_W(17), .Q_W(17), .STAGES(3)) u_div_r (
		.clk, .en, .num_hi({1'b0, pr_s10[32:17]}), .num_lo(pr_s10[16:0]),
		.den(diff_s10), .quo(qr_s13)
	);
	jddm_delay #(.W(37), .N(4)) u_dly_wheel (
		.clk, .en, .d({lim_s9, lneg_s9, rneg_s9, labs_s9, rabs_s9}), .q(side_s13)
	);

	// Stage 14: saturate and scale to the drive range.
	logic [16:0] ml, mr;
	logic [15:0] msl, msr;
	logic [28:0] pwl_s14, pwr_s14;
	logic        lneg_s14, rneg_s14;

	assign ml  = side_s13[36] ? ql_s13 : side_s13[33:17];
	assign mr  = side_s13[36] ? qr_s13 : side_s13[16:0];
	assign msl = (ml > {1'b0, ONE_Q15}) ? ONE_Q15 : ml[15:0];
	assign msr = (mr > {1'b0, ONE_Q15}) ? ONE_Q15 : mr[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			pwl_s14  <= msl * PWM_FULL;
			pwr_s14  <= msr * PWM_FULL;
			lneg_s14 <= side_s13[35];
			rneg_s14 <= side_s13[34];
		end
	end

	logic [33:0] norm_d14;

	jddm_delay #(.W(34), .N(9)) u_dly_norm (
		.clk, .en, .d({xv_s5, yv_s5}), .q(norm_d14)
	);

	// Stage 15: output register.
	logic signed [13:0] pwm_l_s15, pwm_r_s15;
	logic signed [16:0] steer_s15, thr_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			pwm_l_s15 <= lneg_s14 ? -$signed({1'b0, pwl_s14[27:15]})
				: $signed({1'b0, pwl_s14[27:15]});
			pwm_r_s15 <= rneg_s14 ? -$signed({1'b0, pwr_s14[27:15]})
				: $signed({1'b0, pwr_s14[27:15]});
			steer_s15 <= signed'(norm_d14[33:17]);
			thr_s15   <= signed'(norm_d14[16:0]);
		end
	end

	assign drive.left_drive    = pwm_l_s15;
	assign drive.right_drive   = pwm_r_s15;
	assign drive.steer_norm    = steer_s15;
	assign drive.throttle_norm = thr_s15;

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> (drive.left_drive <= 14'sd8190 && drive.left_drive >= -14'sd8190
			&& drive.right_drive <= 14'sd8190 && drive.right_drive >= -14'sd8190))
		else $error("Drive word out of range.");

	a_no_steer: assert property (@(posedge clk) disable iff (!arst_n)
		(drive.valid && drive.steer_norm == '0) |-> (drive.left_drive == drive.right_drive))
		else $error("Wheels differ without steering.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(drive.valid && !drive.ready) |=> (drive.valid && $stable(drive.left_drive)
			&& $stable(drive.steer_norm)))
		else $error("Stalled drive word changed.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!drive.valid) |-> samples.ready)
		else $error("Input refused with an empty output stage.");
endmodule
